// File: rtl/cdsm_pkg.sv
`default_nettype none

package cdsm_pkg;

    localparam int ROWS_TOTAL   = 320;
    localparam int ROWS_VISIBLE = 240;

    localparam int ROW_W = $clog2(ROWS_TOTAL);
    localparam int SUM_W = ROW_W + 1;

    // offset step of one visible screen, kept inside the ring
    localparam int VIS_STEP = ROWS_VISIBLE % ROWS_TOTAL;

    localparam logic [0:0] OP_SET_MODE = 1'b0;
    localparam logic [0:0] OP_FLUSH    = 1'b1;

    localparam logic [0:0] KIND_WINDOW = 1'b0;
    localparam logic [0:0] KIND_SCROLL = 1'b1;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_DOWN = 2'd1,
        MODE_UP   = 2'd2
    } mode_t;

    typedef struct packed {
        logic [0:0]  kind;
        logic [7:0]  win_col_first;
        logic [7:0]  win_col_last;
        logic [8:0]  win_row_first;
        logic [8:0]  win_row_last;
        logic [31:0] pixels_addr;
        logic [8:0]  scroll_start;
        logic        last;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/cdsm_if.sv
`default_nettype none

interface cdsm_in_if;
    logic        valid;
    logic        ready;
    logic [0:0]  op;
    logic [1:0]  mode_request;
    logic [7:0]  col_first;
    logic [7:0]  col_last;
    logic [7:0]  row_first;
    logic [7:0]  row_last;
    logic [31:0] pixels_base;

    modport source (
        output valid, op, mode_request, col_first, col_last, row_first, row_last,
               pixels_base,
        input  ready
    );
    modport sink (
        input  valid, op, mode_request, col_first, col_last, row_first, row_last,
               pixels_base,
        output ready
    );
endinterface

interface cdsm_out_if;
    logic        valid;
    logic        ready;
    logic [0:0]  kind;
    logic [7:0]  win_col_first;
    logic [7:0]  win_col_last;
    logic [8:0]  win_row_first;
    logic [8:0]  win_row_last;
    logic [31:0] pixels_addr;
    logic [8:0]  scroll_start;
    logic        last;

    modport source (
        output valid, kind, win_col_first, win_col_last, win_row_first, win_row_last,
               pixels_addr, scroll_start, last,
        input  ready
    );
    modport sink (
        input  valid, kind, win_col_first, win_col_last, win_row_first, win_row_last,
               pixels_addr, scroll_start, last,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/circular_display_scroll_mapper_unit.sv
`default_nettype none

// Maps rectangles drawn on the visible screen into a ring of panel rows.
// A mode word (op 0) sets the scroll mode, if the request names one, and
// gives no result; a flush word (op 1) gives one or two window commands,
// then a vertical scroll command when scrolling is on, the final one
// flagged by last. The input word is held in one register and its results
// leave through one result register, one result per cycle while the output
// is not stalled. A new word is taken in the cycle the held one finishes,
// and while a finished result still waits on the output.
module circular_display_scroll_mapper_unit (
    input  wire          clk,
    input  wire          rst_n,
    cdsm_in_if.sink      cmd,
    cdsm_out_if.source   rsp
);

    localparam int RW = cdsm_pkg::ROW_W;
    localparam int SW = cdsm_pkg::SUM_W;
    localparam logic [SW-1:0] TOTAL_S = SW'(cdsm_pkg::ROWS_TOTAL);
    localparam logic [SW-1:0] VIS_S   = SW'(cdsm_pkg::ROWS_VISIBLE);
    localparam logic [SW-1:0] STEP_S  = SW'(cdsm_pkg::VIS_STEP);
    localparam logic [SW-1:0] BACK_S  = SW'(cdsm_pkg::ROWS_TOTAL - cdsm_pkg::VIS_STEP);
    localparam logic [SW-1:0] VLAST_S = SW'(cdsm_pkg::ROWS_VISIBLE - 1);

    // held input word
    logic              a_valid_reg, a_valid_next;
    logic [0:0]        a_op_reg;
    logic [1:0]        a_req_reg;
    logic [7:0]        a_c1_reg, a_c2_reg, a_y1_reg, a_y2_reg;
    logic [31:0]       a_base_reg;
    logic [1:0]        a_seq_reg, a_seq_next;

    logic [RW-1:0]     row_offset_reg, row_offset_next;
    cdsm_pkg::mode_t   scroll_mode_reg, scroll_mode_next;

    logic              out_valid_reg, out_valid_next;
    cdsm_pkg::res_t    out_reg, out_next;

    logic              out_load, a_release;

    logic [SW-1:0]     off_ext, down_sum, up_sum, off_down, off_up, off_new;
    logic [SW-1:0]     y1_ext, y2_ext, s1_sum, s2_sum, s1, s2;
    logic [SW-1:0]     ns_sum, ns, scr_sum, scr_down, scr_up, span;
    logic              wrap, clear_mode;
    logic [31:0]       width, skip;
    logic [1:0]        n_res;
    cdsm_pkg::res_t    win1, win2, scroll_res, res_cur;

    always_comb
    begin
        off_ext  = {1'b0, row_offset_reg};
        y1_ext   = SW'(a_y1_reg);
        y2_ext   = SW'(a_y2_reg);

        down_sum = off_ext + STEP_S;
        off_down = (down_sum >= TOTAL_S) ? down_sum - TOTAL_S : down_sum;
        up_sum   = off_ext + BACK_S;
        off_up   = (up_sum >= TOTAL_S) ? up_sum - TOTAL_S : up_sum;

        if (scroll_mode_reg == cdsm_pkg::MODE_DOWN && a_y1_reg == 8'd0)
            off_new = off_down;
        else if (scroll_mode_reg == cdsm_pkg::MODE_UP && y2_ext == VLAST_S)
            off_new = off_up;
        else
            off_new = off_ext;

        clear_mode = (scroll_mode_reg == cdsm_pkg::MODE_DOWN && y2_ext >= VLAST_S)
                  || (scroll_mode_reg == cdsm_pkg::MODE_UP && a_y1_reg == 8'd0);

        // visible rows are below 256, so one subtract folds into the ring
        s1_sum = y1_ext + off_new;
        s1     = (s1_sum >= TOTAL_S) ? s1_sum - TOTAL_S : s1_sum;
        s2_sum = y2_ext + off_new;
        s2     = (s2_sum >= TOTAL_S) ? s2_sum - TOTAL_S : s2_sum;
        wrap   = s2 < s1;

        ns_sum   = off_new + y2_ext + SW'(1);
        ns       = (ns_sum >= TOTAL_S) ? ns_sum - TOTAL_S : ns_sum;
        scr_sum  = TOTAL_S - ns + VIS_S;
        scr_down = (scr_sum >= TOTAL_S) ? scr_sum - TOTAL_S : scr_sum;
        scr_up   = (s1 == '0) ? '0 : TOTAL_S - s1;

        span  = TOTAL_S - s1;
        width = {24'd0, a_c2_reg} - {24'd0, a_c1_reg} + 32'd1;
        skip  = 32'(width * {{(32-SW){1'b0}}, span});

        win1.kind          = cdsm_pkg::KIND_WINDOW;
        win1.win_col_first = a_c1_reg;
        win1.win_col_last  = a_c2_reg;
        win1.win_row_first = 9'(s1);
        win1.win_row_last  = wrap ? 9'(TOTAL_S - SW'(1)) : 9'(s2);
        win1.pixels_addr   = a_base_reg;
        win1.scroll_start  = '0;
        win1.last          = 1'b0;

        win2               = win1;
        win2.win_row_first = '0;
        win2.win_row_last  = 9'(s2);
        win2.pixels_addr   = a_base_reg + {skip[30:0], 1'b0};

        scroll_res              = '0;
        scroll_res.kind         = cdsm_pkg::KIND_SCROLL;
        scroll_res.scroll_start = (scroll_mode_reg == cdsm_pkg::MODE_DOWN)
                                  ? 9'(scr_down) : 9'(scr_up);

        n_res = 2'd1 + {1'b0, wrap}
              + {1'b0, scroll_mode_reg != cdsm_pkg::MODE_NONE};

        case (a_seq_reg)
            2'd0:    res_cur = win1;
            2'd1:    res_cur = wrap ? win2 : scroll_res;
            default: res_cur = scroll_res;
        endcase
        res_cur.last = (a_seq_reg == n_res - 2'd1);
    end

    assign out_load  = a_valid_reg && a_op_reg == cdsm_pkg::OP_FLUSH
                    && (!out_valid_reg || rsp.ready);
    assign a_release = a_valid_reg
                    && (a_op_reg == cdsm_pkg::OP_SET_MODE || (out_load && res_cur.last));
    assign cmd.ready = !a_valid_reg || a_release;

    always_comb
    begin
        a_valid_next = (cmd.valid && cmd.ready) || (a_valid_reg && !a_release);

        row_offset_next  = row_offset_reg;
        scroll_mode_next = scroll_mode_reg;
        if (a_release)
        begin
            if (a_op_reg == cdsm_pkg::OP_SET_MODE)
            begin
                if (a_req_reg <= 2'(cdsm_pkg::MODE_UP))
                    scroll_mode_next = cdsm_pkg::mode_t'(a_req_reg);
            end
            else
            begin
                row_offset_next = RW'(off_new);
                if (clear_mode)
                    scroll_mode_next = cdsm_pkg::MODE_NONE;
            end
        end

        if (a_release)
            a_seq_next = 2'd0;
        else if (out_load)
            a_seq_next = a_seq_reg + 2'd1;
        else
            a_seq_next = a_seq_reg;

        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        out_next = out_load ? res_cur : out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            a_seq_reg       <= 2'd0;
            row_offset_reg  <= '0;
            scroll_mode_reg <= cdsm_pkg::MODE_NONE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            a_valid_reg     <= a_valid_next;
            a_seq_reg       <= a_seq_next;
            row_offset_reg  <= row_offset_next;
            scroll_mode_reg <= scroll_mode_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            a_op_reg   <= cmd.op;
            a_req_reg  <= cmd.mode_request;
            a_c1_reg   <= cmd.col_first;
            a_c2_reg   <= cmd.col_last;
            a_y1_reg   <= cmd.row_first;
            a_y2_reg   <= cmd.row_last;
            a_base_reg <= cmd.pixels_base;
        end
        out_reg <= out_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.kind          = out_reg.kind;
    assign rsp.win_col_first = out_reg.win_col_first;
    assign rsp.win_col_last  = out_reg.win_col_last;
    assign rsp.win_row_first = out_reg.win_row_first;
    assign rsp.win_row_last  = out_reg.win_row_last;
    assign rsp.pixels_addr   = out_reg.pixels_addr;
    assign rsp.scroll_start  = out_reg.scroll_start;
    assign rsp.last          = out_reg.last;

`ifndef SYNTHESIS
    a_offset_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, row_offset_reg} < TOTAL_S)
        else $error("row offset left the ring");

    a_scroll_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.kind == cdsm_pkg::KIND_SCROLL |-> rsp.last)
        else $error("scroll command not final result of its word");

    a_seq_only_flush: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && a_seq_reg != 2'd0 |-> a_op_reg == cdsm_pkg::OP_FLUSH)
        else $error("result sequence running for a mode word");

    a_seq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        a_seq_reg != 2'd3)
        else $error("more than three results for one word");
`endif

endmodule

`default_nettype wire
